// ----- rtl/core/bpu_pkg.sv -----
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types, codes and helper functions of the bitmap pixel unpacker.
// ----------------------------------------------------------------------------
package bpu_pkg;

	// Default palette depth
	localparam int PALETTE_DEPTH_DEF = 256;

	// Depth at which the eight-bit indexed mode has a full palette
	localparam int FULL_PALETTE = 256;

	// Field widths
	localparam int WORD_W    = 32;
	localparam int BYTE_W    = 8;
	localparam int PARTIAL_W = 24;
	localparam int SHIFT_W   = 5;
	localparam int CFG_IDX_W = 3;

	// Register reset values
	localparam logic [WORD_W-1:0] RED_MASK_RST   = 32'h00ff_0000;
	localparam logic [WORD_W-1:0] GREEN_MASK_RST = 32'h0000_ff00;
	localparam logic [WORD_W-1:0] BLUE_MASK_RST  = 32'h0000_00ff;
	localparam logic [WORD_W-1:0] ALPHA_MASK_RST = 32'h0000_0000;

	// Input word kinds; code 3 is ignored
	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_ENTRY = 2'd1,
		KIND_DATA  = 2'd2
	} kind_t;

	// Pixel formats
	typedef enum logic [1:0] {
		MODE_1BPP   = 2'd0,
		MODE_8BPP   = 2'd1,
		MODE_RGB24  = 2'd2,
		MODE_RGBA32 = 2'd3
	} mode_t;

	// Result status codes
	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_SMALL    = 2'd1,
		STS_OVERFLOW = 2'd2
	} status_t;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE        = 3'd0,
		CFG_REMIX       = 3'd1,
		CFG_RED_MASK    = 3'd2,
		CFG_GREEN_MASK  = 3'd3,
		CFG_BLUE_MASK   = 3'd4,
		CFG_ALPHA_MASK  = 3'd5
	} cfg_idx_t;

	// Trailing zero count of a mask (zero mask gives 0; its field is 0 anyway)
	function automatic logic [SHIFT_W-1:0] trail_zeros(logic [WORD_W-1:0] mask);
		logic [SHIFT_W-1:0] n;
		n = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (mask[i]) n = SHIFT_W'(i);
		end
		return n;
	endfunction

	// One color channel pulled out of a raw palette word
	function automatic logic [BYTE_W-1:0] chan_field(logic [WORD_W-1:0] word,
			logic [WORD_W-1:0] mask, logic [SHIFT_W-1:0] sh);
		logic [WORD_W-1:0] v;
		v = (word & mask) >> sh;
		return v[BYTE_W-1:0];
	endfunction

endpackage

// ----- rtl/core/bpu_if.sv -----
// ----------------------------------------------------------------------------
// bpu_if
// Valid/ready channels of the bitmap pixel unpacker: input words, result
// words and register writes.
// ----------------------------------------------------------------------------
interface bpu_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] entry_word;
	logic [7:0]  data_byte;

	modport source(output valid, kind, entry_word, data_byte, input ready);
	modport sink(input valid, kind, entry_word, data_byte, output ready);
endinterface

interface bpu_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel;
	logic [1:0]  status;
	logic        last;

	modport source(output valid, pixel, status, last, input ready);
	modport sink(input valid, pixel, status, last, output ready);
endinterface

interface bpu_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/bpu_ram.sv -----
// ----------------------------------------------------------------------------
// bpu_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module bpu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/bmp_pixel_unpacker_unit.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_unpacker_unit
// Turns uncompressed bitmap pixel bytes into packed r,g,b,a words.
// ----------------------------------------------------------------------------
// While the result path does not stall, one input word is taken per cycle,
// except a one-bit-per-pixel data byte, which holds the input while its eight
// pixels are looked up one per cycle through the single read port of the
// palette RAM. Results pass through the lookup stage, then the output
// register, and the input keeps flowing while one result waits at the output.
// The palette RAM needs no clearing after reset: the entry count only lets
// written entries be read, so the block is ready as soon as reset ends.
// Registers are to be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module bmp_pixel_unpacker_unit #(
	parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bpu_cfg_if.sink       cfg,
	bpu_in_if.sink        din,
	bpu_out_if.source     dout
);

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int CW = $clog2(PALETTE_DEPTH + 1);
	localparam bit BYTE_PAL_OK = (PALETTE_DEPTH == bpu_pkg::FULL_PALETTE);

	// Configuration registers
	bpu_pkg::mode_t                       mode_q;
	logic                                 remix_q;
	logic [bpu_pkg::WORD_W-1:0]           rmask_q, gmask_q, bmask_q, amask_q;
	logic [bpu_pkg::SHIFT_W-1:0]          rsh_q, gsh_q, bsh_q, ash_q;

	// Decode state
	logic [CW-1:0]                        count_q, count_d;
	logic [1:0]                           phase_q, phase_d;
	logic [bpu_pkg::PARTIAL_W-1:0]        partial_q, partial_d;

	// One-bit sequencer
	logic                                 seq_busy_q, seq_busy_d;
	logic [2:0]                           seq_bit_q, seq_bit_d;
	logic [bpu_pkg::BYTE_W-1:0]           seq_byte_q, seq_byte_d;

	// Lookup stage and output register
	logic                                 s1_valid_q;
	logic                                 s1_lookup_s1;
	logic [bpu_pkg::WORD_W-1:0]           s1_pixel_s1;
	logic [1:0]                           s1_status_s1;
	logic                                 s1_last_s1;
	logic                                 out_valid_q;
	logic [bpu_pkg::WORD_W-1:0]           out_pixel_q;
	logic [1:0]                           out_status_q;
	logic                                 out_last_q;

	// Issue controls
	logic                                 acc, s1_free, out_load;
	logic                                 s1_load, ld_lookup, ld_last;
	logic [bpu_pkg::WORD_W-1:0]           ld_pixel;
	logic [1:0]                           ld_status;
	logic                                 pal_we, pal_re;
	logic [AW-1:0]                        pal_raddr;
	logic [bpu_pkg::WORD_W-1:0]           pal_wdata, pal_rdata, remixed;
	logic                                 pal_full;

	// Register write port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bpu_pkg::MODE_RGBA32;
			remix_q <= 1'b0;
			rmask_q <= bpu_pkg::RED_MASK_RST;
			gmask_q <= bpu_pkg::GREEN_MASK_RST;
			bmask_q <= bpu_pkg::BLUE_MASK_RST;
			amask_q <= bpu_pkg::ALPHA_MASK_RST;
			rsh_q   <= bpu_pkg::trail_zeros(bpu_pkg::RED_MASK_RST);
			gsh_q   <= bpu_pkg::trail_zeros(bpu_pkg::GREEN_MASK_RST);
			bsh_q   <= bpu_pkg::trail_zeros(bpu_pkg::BLUE_MASK_RST);
			ash_q   <= bpu_pkg::trail_zeros(bpu_pkg::ALPHA_MASK_RST);
		end else if (cfg.valid) begin
			case (cfg.index)
				bpu_pkg::CFG_MODE: begin
					mode_q <= bpu_pkg::mode_t'(cfg.data[1:0]);
				end
				bpu_pkg::CFG_REMIX: begin
					remix_q <= cfg.data[0];
				end
				bpu_pkg::CFG_RED_MASK: begin
					rmask_q <= cfg.data;
					rsh_q   <= bpu_pkg::trail_zeros(cfg.data);
				end
				bpu_pkg::CFG_GREEN_MASK: begin
					gmask_q <= cfg.data;
					gsh_q   <= bpu_pkg::trail_zeros(cfg.data);
				end
				bpu_pkg::CFG_BLUE_MASK: begin
					bmask_q <= cfg.data;
					bsh_q   <= bpu_pkg::trail_zeros(cfg.data);
				end
				bpu_pkg::CFG_ALPHA_MASK: begin
					amask_q <= cfg.data;
					ash_q   <= bpu_pkg::trail_zeros(cfg.data);
				end
				default: begin
				end
			endcase
		end
	end

	// Palette entry rebuild from the channel masks
	assign remixed = {bpu_pkg::chan_field(din.entry_word, rmask_q, rsh_q),
		bpu_pkg::chan_field(din.entry_word, gmask_q, gsh_q),
		bpu_pkg::chan_field(din.entry_word, bmask_q, bsh_q),
		bpu_pkg::chan_field(din.entry_word, amask_q, ash_q)};
	assign pal_wdata = remix_q ? remixed : din.entry_word;

	// Handshake
	assign s1_free   = !s1_valid_q || !out_valid_q || dout.ready;
	assign out_load  = s1_valid_q && (!out_valid_q || dout.ready);
	assign din.ready = !seq_busy_q && s1_free;
	assign acc       = din.valid && din.ready;
	assign pal_full  = (count_q == CW'(PALETTE_DEPTH));

	// Decode of the accepted word and the one-bit sequencer
	always_comb begin
		count_d    = count_q;
		phase_d    = phase_q;
		partial_d  = partial_q;
		seq_busy_d = seq_busy_q;
		seq_bit_d  = seq_bit_q;
		seq_byte_d = seq_byte_q;
		s1_load    = 1'b0;
		ld_lookup  = 1'b0;
		ld_last    = 1'b1;
		ld_pixel   = '0;
		ld_status  = bpu_pkg::STS_OK;
		pal_we     = 1'b0;
		pal_raddr  = '0;

		if (seq_busy_q && s1_free) begin
			// remaining pixels of a one-bit byte, MSB first
			s1_load   = 1'b1;
			ld_lookup = 1'b1;
			ld_last   = (seq_bit_q == 3'd0);
			pal_raddr = AW'(seq_byte_q[seq_bit_q]);
			seq_bit_d = seq_bit_q - 3'd1;
			if (seq_bit_q == 3'd0) seq_busy_d = 1'b0;
		end else if (acc) begin
			case (din.kind)
				bpu_pkg::KIND_START: begin
					count_d   = '0;
					phase_d   = '0;
					partial_d = '0;
				end
				bpu_pkg::KIND_ENTRY: begin
					if (pal_full) begin
						s1_load   = 1'b1;
						ld_status = bpu_pkg::STS_OVERFLOW;
					end else begin
						pal_we  = 1'b1;
						count_d = count_q + CW'(1);
					end
				end
				bpu_pkg::KIND_DATA: begin
					unique case (mode_q)
						bpu_pkg::MODE_1BPP: begin
							s1_load = 1'b1;
							if (count_q < CW'(2)) begin
								ld_status = bpu_pkg::STS_SMALL;
							end else begin
								ld_lookup  = 1'b1;
								ld_last    = 1'b0;
								pal_raddr  = AW'(din.data_byte[7]);
								seq_busy_d = 1'b1;
								seq_bit_d  = 3'd6;
								seq_byte_d = din.data_byte;
							end
						end
						bpu_pkg::MODE_8BPP: begin
							s1_load = 1'b1;
							if (BYTE_PAL_OK && pal_full) begin
								ld_lookup = 1'b1;
								pal_raddr = din.data_byte[AW-1:0];
							end else begin
								ld_status = bpu_pkg::STS_SMALL;
							end
						end
						bpu_pkg::MODE_RGB24: begin
							if (phase_q[1]) begin
								s1_load   = 1'b1;
								ld_pixel  = {partial_q[15:0], din.data_byte, 8'h00};
								phase_d   = '0;
								partial_d = '0;
							end else begin
								partial_d = {partial_q[15:0], din.data_byte};
								phase_d   = phase_q + 2'd1;
							end
						end
						bpu_pkg::MODE_RGBA32: begin
							if (phase_q == 2'd3) begin
								s1_load   = 1'b1;
								ld_pixel  = {partial_q, din.data_byte};
								phase_d   = '0;
								partial_d = '0;
							end else begin
								partial_d = {partial_q[15:0], din.data_byte};
								phase_d   = phase_q + 2'd1;
							end
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	assign pal_re = s1_load && ld_lookup;

	// Palette memory
	bpu_ram #(
		.WIDTH (bpu_pkg::WORD_W),
		.DEPTH (PALETTE_DEPTH)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (count_q[AW-1:0]),
		.wdata (pal_wdata),
		.re    (pal_re),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			phase_q     <= '0;
			partial_q   <= '0;
			seq_busy_q  <= 1'b0;
			seq_bit_q   <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q    <= count_d;
			phase_q    <= phase_d;
			partial_q  <= partial_d;
			seq_busy_q <= seq_busy_d;
			seq_bit_q  <= seq_bit_d;
			if (s1_load) s1_valid_q <= 1'b1;
			else if (s1_free) s1_valid_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;
			else if (dout.ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		seq_byte_q <= seq_byte_d;
		if (s1_load) begin
			s1_lookup_s1 <= ld_lookup;
			s1_pixel_s1  <= ld_pixel;
			s1_status_s1 <= ld_status;
			s1_last_s1   <= ld_last;
		end
		if (out_load) begin
			out_pixel_q  <= s1_lookup_s1 ? pal_rdata : s1_pixel_s1;
			out_status_q <= s1_status_s1;
			out_last_q   <= s1_last_s1;
		end
	end

	assign dout.valid  = out_valid_q;
	assign dout.pixel  = out_pixel_q;
	assign dout.status = out_status_q;
	assign dout.last   = out_last_q;

endmodule

// ----- rtl/core/bpu_checker.sv -----
// ----------------------------------------------------------------------------
// bpu_checker
// Port-level checks of the bitmap pixel unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module bpu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_pixel,
	input logic [1:0]  out_status,
	input logic        out_last
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel)
			&& $stable(out_status) && $stable(out_last))
		else $error("result word changed while stalled");

	// Error words are zero and close their item
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != bpu_pkg::STS_OK |-> out_pixel == 32'd0 && out_last)
		else $error("error word not zero or not last");

	// Pixels of one byte follow each other without a gap
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("gap inside a one-bit pixel burst");

endmodule

bind bmp_pixel_unpacker_unit bpu_checker u_bpu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.out_pixel  (dout.pixel),
	.out_status (dout.status),
	.out_last   (dout.last)
);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bmp_pixel_unpacker_unit. A scoreboard class tracks
// the palette, the byte phase and the register settings, predicts the result
// words of every accepted input word, and compares each result word field by
// field. Directed words cover edge cases; random phases then follow, each
// with its own register settings. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int         PAL_DEPTH    = bpu_pkg::PALETTE_DEPTH_DEF;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam int         SETTLE       = 16;
	localparam int         LONG_HOLD    = 120;
	localparam int         QUIET_LIMIT  = 4000;
	localparam int         RANDOM_WORDS = 30;

	typedef struct packed {
		logic [31:0]      pixel;
		bpu_pkg::status_t status;
		logic             last;
	} pixel_t;

	// Tracks the block state and holds the pixel words still to come
	class pixel_scoreboard;
		logic [31:0]    palette [PAL_DEPTH];
		logic [8:0]     pal_count;
		logic [1:0]     phase;
		logic [23:0]    partial;
		bpu_pkg::mode_t mode;
		logic           remix_on;
		logic [31:0]    red_mask, green_mask, blue_mask, alpha_mask;
		pixel_t         expected_pixels[$];
		int             mismatches;

		function new();
			pal_count  = '0;
			phase      = '0;
			partial    = '0;
			mode       = bpu_pkg::MODE_RGBA32;
			remix_on   = 1'b0;
			red_mask   = bpu_pkg::RED_MASK_RST;
			green_mask = bpu_pkg::GREEN_MASK_RST;
			blue_mask  = bpu_pkg::BLUE_MASK_RST;
			alpha_mask = bpu_pkg::ALPHA_MASK_RST;
			mismatches = 0;
		endfunction

		function void set_reg(bpu_pkg::cfg_idx_t idx, logic [31:0] val);
			case (idx)
			bpu_pkg::CFG_MODE:       mode = bpu_pkg::mode_t'(val[1:0]);
			bpu_pkg::CFG_REMIX:      remix_on = val[0];
			bpu_pkg::CFG_RED_MASK:   red_mask = val;
			bpu_pkg::CFG_GREEN_MASK: green_mask = val;
			bpu_pkg::CFG_BLUE_MASK:  blue_mask = val;
			bpu_pkg::CFG_ALPHA_MASK: alpha_mask = val;
			default: ;
			endcase
		endfunction

		// Masked field shifted down by the mask's trailing zeros, low byte kept
		function logic [7:0] channel(logic [31:0] word, logic [31:0] mask);
			logic [31:0] field;
			int sh;
			if (mask == '0) return '0;
			sh = 0;
			while (!mask[sh] && sh < 31) sh++;
			field = (word & mask) >> sh;
			return field[7:0];
		endfunction

		function void add_pixel(logic [31:0] pixel, bpu_pkg::status_t status, logic last);
			pixel_t px;
			px.pixel  = pixel;
			px.status = status;
			px.last   = last;
			expected_pixels.push_back(px);
		endfunction

		// Data byte decode by pixel format
		function void decode_byte(logic [7:0] b);
			case (mode)
			bpu_pkg::MODE_1BPP: begin
				if (pal_count < 2) begin
					add_pixel('0, bpu_pkg::STS_SMALL, 1'b1);
				end else begin
					// MSB first
					for (int i = 7; i >= 0; i--)
						add_pixel(palette[b[i]], bpu_pkg::STS_OK, i == 0);
				end
				return;
			end
			bpu_pkg::MODE_8BPP: begin
				if (pal_count < bpu_pkg::FULL_PALETTE)
					add_pixel('0, bpu_pkg::STS_SMALL, 1'b1);
				else
					add_pixel(palette[b], bpu_pkg::STS_OK, 1'b1);
				return;
			end
			bpu_pkg::MODE_RGB24: begin
				// two stored bytes complete it, even if left from another mode
				if (phase >= 2) begin
					add_pixel({partial[15:0], b, 8'h00}, bpu_pkg::STS_OK, 1'b1);
					phase   = '0;
					partial = '0;
					return;
				end
			end
			default: begin
				if (phase == 3) begin
					add_pixel({partial, b}, bpu_pkg::STS_OK, 1'b1);
					phase   = '0;
					partial = '0;
					return;
				end
			end
			endcase
			partial = {partial[15:0], b};
			phase   = phase + 2'd1;
		endfunction

		// Accepted input word
		function void note_word(logic [1:0] k, logic [31:0] w, logic [7:0] b);
			case (k)
			bpu_pkg::KIND_START: begin
				pal_count = '0;
				phase     = '0;
				partial   = '0;
			end
			bpu_pkg::KIND_ENTRY: begin
				if (pal_count >= PAL_DEPTH) begin
					add_pixel('0, bpu_pkg::STS_OVERFLOW, 1'b1);
				end else begin
					palette[pal_count[7:0]] = remix_on ?
						{channel(w, red_mask), channel(w, green_mask),
						 channel(w, blue_mask), channel(w, alpha_mask)} : w;
					pal_count = pal_count + 9'd1;
				end
			end
			bpu_pkg::KIND_DATA: decode_byte(b);
			default: ;
			endcase
		endfunction

		// Accepted result word against the oldest pending one
		function void check_pixel(logic [31:0] p, logic [1:0] s, logic l);
			pixel_t exp_px;
			if (expected_pixels.size() == 0) begin
				$error("unexpected result word: pixel %h status %0d last %0b", p, s, l);
				mismatches++;
				return;
			end
			exp_px = expected_pixels.pop_front();
			if (p !== exp_px.pixel) begin
				$error("pixel: expected %h, actual %h", exp_px.pixel, p);
				mismatches++;
			end
			if (s !== exp_px.status) begin
				$error("status: expected %0d, actual %0d", exp_px.status, s);
				mismatches++;
			end
			if (l !== exp_px.last) begin
				$error("last: expected %0b, actual %0b", exp_px.last, l);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on = 1'b1;
	bit   long_hold = 1'b0;
	int   words_sent = 0;
	int   quiet_cycles = 0;

	pixel_scoreboard sb = new();

	bpu_cfg_if cfg_bus();
	bpu_in_if  in_bus();
	bpu_out_if out_bus();

	bmp_pixel_unpacker_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.din    (in_bus),
		.dout   (out_bus)
	);

	always #1 clk = ~clk;

	// Input gap: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [31:0] pick_mask();
		logic [63:0] field;
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2: return 32'h8000_0000;
		3: return 32'h0000_0001;
		4, 5: begin
			field = ((64'd1 << $urandom_range(1, 12)) - 64'd1) << $urandom_range(0, 31);
			return field[31:0];
		end
		default: return $urandom;
		endcase
	endfunction

	// One input word; valid stays high unless a gap follows
	task automatic send_word(input logic [1:0] k, input logic [31:0] w, input logic [7:0] b);
		int gap;
		in_bus.valid      <= 1'b1;
		in_bus.kind       <= k;
		in_bus.entry_word <= w;
		in_bus.data_byte  <= b;
		do @(posedge clk); while (!in_bus.ready);
		if (k != KIND_UNUSED) words_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_start();
		send_word(bpu_pkg::KIND_START, $urandom, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_entry(input logic [31:0] w);
		send_word(bpu_pkg::KIND_ENTRY, w, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(bpu_pkg::KIND_DATA, $urandom, b);
	endtask

	task automatic write_reg(input bpu_pkg::cfg_idx_t idx, input logic [31:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Sender pauses until every expected result word is out, then lets the pipe empty
	task automatic drain_and_settle();
		in_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Handshake monitor: predict on input, check on output
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				sb.set_reg(bpu_pkg::cfg_idx_t'(cfg_bus.index), cfg_bus.data);
			if (in_bus.valid && in_bus.ready)
				sb.note_word(in_bus.kind, in_bus.entry_word, in_bus.data_byte);
			if (out_bus.valid && out_bus.ready)
				sb.check_pixel(out_bus.pixel, out_bus.status, out_bus.last);
		end
	end

	// Watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int len;
		out_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				out_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_bus.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
				out_bus.ready <= 1'b0;
				repeat (len) @(posedge clk);
				out_bus.ready <= 1'b1;
			end else begin
				out_bus.ready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		bpu_pkg::mode_t m;
		int             n;
		int             random_end;
		arst_n            = 1'b0;
		in_bus.valid      = 1'b0;
		in_bus.kind       = bpu_pkg::KIND_START;
		in_bus.entry_word = '0;
		in_bus.data_byte  = '0;
		cfg_bus.valid     = 1'b0;
		cfg_bus.index     = bpu_pkg::CFG_MODE;
		cfg_bus.data      = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// 32-bit mode from reset: extreme bytes, ignored kind, partial pixel left
		send_start();
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h80);
		send_byte(8'h01);
		send_word(KIND_UNUSED, 32'hffff_ffff, 8'hff);
		repeat (4) send_byte(8'hff);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);

		// 24-bit mode picks up two of the three stored bytes; extreme masks for later
		drain_and_settle();
		write_reg(bpu_pkg::CFG_MODE, 32'(bpu_pkg::MODE_RGB24));
		write_reg(bpu_pkg::CFG_REMIX, 32'd1);
		write_reg(bpu_pkg::CFG_RED_MASK, 32'hffff_ffff);
		write_reg(bpu_pkg::CFG_GREEN_MASK, 32'h8000_0000);
		write_reg(bpu_pkg::CFG_BLUE_MASK, 32'h0000_0000);
		write_reg(bpu_pkg::CFG_ALPHA_MASK, 32'h0000_ff00);
		send_byte(8'h9a);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		send_byte(8'haa);
		send_byte(8'hbb);

		// 1bpp with remixed entries; too-small palette first
		drain_and_settle();
		write_reg(bpu_pkg::CFG_MODE, 32'(bpu_pkg::MODE_1BPP));
		send_byte(8'h5a);
		send_entry(32'h8000_00ff);
		send_byte(8'h3c);
		send_entry(32'h7fff_1200);
		send_byte(8'ha5);
		send_byte(8'h00);
		send_byte(8'hff);

		// back to 32-bit mid-pixel: the two 24-bit bytes are still held
		drain_and_settle();
		write_reg(bpu_pkg::CFG_MODE, 32'(bpu_pkg::MODE_RGBA32));
		write_reg(bpu_pkg::CFG_REMIX, 32'd0);
		send_byte(8'hcc);
		send_byte(8'hdd);

		// full palette for 8bpp, then overflow entries
		drain_and_settle();
		write_reg(bpu_pkg::CFG_MODE, 32'(bpu_pkg::MODE_8BPP));
		write_reg(bpu_pkg::CFG_REMIX, 32'($urandom_range(0, 1)));
		idle_on = 1'b1;
		send_start();
		repeat (PAL_DEPTH) send_entry($urandom);
		repeat (2) send_entry($urandom);
		send_byte(8'h00);
		send_byte(8'hff);
		repeat (6) send_byte(8'($urandom_range(0, 255)));

		// long hold-off on the result side while 1bpp bytes keep coming
		drain_and_settle();
		write_reg(bpu_pkg::CFG_MODE, 32'(bpu_pkg::MODE_1BPP));
		idle_on   = 1'b0;
		long_hold = 1'b1;
		repeat (12) send_byte(8'($urandom_range(0, 255)));

		// random phases, each with its own settings
		random_end = words_sent + RANDOM_WORDS;
		while (words_sent < random_end) begin
			drain_and_settle();
			m = bpu_pkg::mode_t'($urandom_range(0, 3));
			write_reg(bpu_pkg::CFG_MODE, 32'(m));
			if ($urandom_range(0, 1))
				write_reg(bpu_pkg::CFG_REMIX, 32'($urandom_range(0, 1)));
			for (int i = bpu_pkg::CFG_RED_MASK; i <= bpu_pkg::CFG_ALPHA_MASK; i++)
				if ($urandom_range(0, 2) == 0) write_reg(bpu_pkg::cfg_idx_t'(i), pick_mask());
			idle_on = ($urandom_range(0, 9) < 7);
			if ($urandom_range(0, 9) < 2) begin
				// noise: any kind, any content
				repeat ($urandom_range(6, 12))
					send_word(2'($urandom_range(0, 3)), $urandom, 8'($urandom_range(0, 255)));
			end else begin
				case (m)
				bpu_pkg::MODE_1BPP: begin
					if ($urandom_range(0, 4) != 0) begin
						send_start();
						repeat ($urandom_range(2, 6)) send_entry($urandom);
					end
					repeat ($urandom_range(3, 10)) send_byte(8'($urandom_range(0, 255)));
				end
				bpu_pkg::MODE_8BPP: begin
					repeat ($urandom_range(3, 10)) send_byte(8'($urandom_range(0, 255)));
				end
				default: begin
					if ($urandom_range(0, 1)) send_start();
					n = (m == bpu_pkg::MODE_RGB24) ? 3 : 4;
					repeat ($urandom_range(1, 5))
						repeat (n) send_byte(8'($urandom_range(0, 255)));
					// leave a partial pixel for the next phase now and then
					repeat ($urandom_range(0, n - 1)) send_byte(8'($urandom_range(0, 255)));
				end
				endcase
			end
		end

		drain_and_settle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
